>>> hw/rtl/cbor_enc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cbor_enc_pkg;

   // Request command codes.
   localparam logic [3:0] CMD_NULL   = 4'd0;
   localparam logic [3:0] CMD_UNDEF  = 4'd1;
   localparam logic [3:0] CMD_BOOL   = 4'd2;
   localparam logic [3:0] CMD_UINT   = 4'd3;
   localparam logic [3:0] CMD_NEGINT = 4'd4;
   localparam logic [3:0] CMD_DOUBLE = 4'd5;
   localparam logic [3:0] CMD_TEXT   = 4'd6;
   localparam logic [3:0] CMD_BYTES  = 4'd7;
   localparam logic [3:0] CMD_ARRAY  = 4'd8;
   localparam logic [3:0] CMD_MAP    = 4'd9;
   localparam logic [3:0] CMD_RAW    = 4'd10;

   // Major types, already placed in the top three bits of the head byte.
   localparam logic [7:0] MT_UINT  = 8'h00;
   localparam logic [7:0] MT_NEG   = 8'h20;
   localparam logic [7:0] MT_BYTES = 8'h40;
   localparam logic [7:0] MT_TEXT  = 8'h60;
   localparam logic [7:0] MT_ARRAY = 8'h80;
   localparam logic [7:0] MT_MAP   = 8'ha0;

   // Simple values and float heads.
   localparam logic [7:0] SIMPLE_FALSE = 8'hf4;
   localparam logic [7:0] SIMPLE_TRUE  = 8'hf5;
   localparam logic [7:0] SIMPLE_NULL  = 8'hf6;
   localparam logic [7:0] SIMPLE_UNDEF = 8'hf7;
   localparam logic [7:0] HEAD_HALF    = 8'hf9;
   localparam logic [7:0] HEAD_SINGLE  = 8'hfa;
   localparam logic [7:0] HEAD_DOUBLE  = 8'hfb;

   // Additional-information codes for 1, 2, 4 and 8 argument bytes.
   localparam logic [4:0] AI_ONE   = 5'd24;
   localparam logic [4:0] AI_TWO   = 5'd25;
   localparam logic [4:0] AI_FOUR  = 5'd26;
   localparam logic [4:0] AI_EIGHT = 5'd27;

   // Queue between the classifier and the serializer.
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   typedef struct packed {
      logic [3:0]  command;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // One classified element: the head byte, then arg_len argument bytes taken
   // from the top of arg downward.
   typedef struct packed {
      logic [7:0]  head;
      logic [63:0] arg;
      logic [3:0]  arg_len;
   } elem_type;

endpackage
`default_nettype wire

>>> hw/rtl/cbor_enc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cbor_enc_front import cbor_enc_pkg::*; (
   input  wire logic     push,
   output logic          full,
   input  wire req_type  req_data,
   input  wire logic     q_full,
   output logic          q_push,
   output elem_type      q_data
);

   // Shortest head form for a major type and a 64-bit argument.
   function automatic elem_type make_head(logic [7:0] major, logic [63:0] arg);
      elem_type e;
      e = '0;
      if (arg[63:5] == '0 && arg[4:0] < AI_ONE) begin
         e.head = major | {3'b000, arg[4:0]};
      end else if (arg[63:8] == '0) begin
         e.head    = major | {3'b000, AI_ONE};
         e.arg     = {arg[7:0], 56'd0};
         e.arg_len = 4'd1;
      end else if (arg[63:16] == '0) begin
         e.head    = major | {3'b000, AI_TWO};
         e.arg     = {arg[15:0], 48'd0};
         e.arg_len = 4'd2;
      end else if (arg[63:32] == '0) begin
         e.head    = major | {3'b000, AI_FOUR};
         e.arg     = {arg[31:0], 32'd0};
         e.arg_len = 4'd4;
      end else begin
         e.head    = major | {3'b000, AI_EIGHT};
         e.arg     = arg;
         e.arg_len = 4'd8;
      end
      return e;
   endfunction

   logic        d_sign;
   logic [10:0] d_exp;
   logic [51:0] d_man;
   logic        d_nan;
   logic [10:0] e_adj;
   logic [22:0] sub_sig;
   logic [4:0]  sub_sh;
   logic        f_ok;
   logic [31:0] f_bits;
   logic [7:0]  f_exp;
   logic [22:0] f_man;
   logic [7:0]  h_exp_adj;
   logic [4:0]  h_sh;
   logic [23:0] h_sig;
   logic [23:0] h_shifted;
   logic        h_ok;
   logic [15:0] h_bits;
   elem_type    dbl_elem;
   elem_type    elem;
   logic        cmd_ok;

   assign d_sign = req_data.value[63];
   assign d_exp  = req_data.value[62:52];
   assign d_man  = req_data.value[51:0];
   assign d_nan  = (d_exp == 11'h7ff) && (d_man != '0);

   // Double to single, exact only.
   assign e_adj   = d_exp - 11'd896;
   assign sub_sig = {1'b1, d_man[51:30]};
   assign sub_sh  = 5'(11'd896 - d_exp);

   always_comb begin
      f_ok   = 1'b0;
      f_bits = {d_sign, 31'd0};
      if (d_exp == '0 && d_man == '0) begin
         f_ok = 1'b1;
      end else if (d_exp == 11'h7ff) begin
         f_ok   = 1'b1;
         f_bits = {d_sign, 8'hff, 23'd0};
      end else if (d_exp >= 11'd897 && d_exp <= 11'd1150) begin
         f_ok   = (d_man[28:0] == '0);
         f_bits = {d_sign, e_adj[7:0], d_man[51:29]};
      end else if (d_exp >= 11'd874 && d_exp <= 11'd896) begin
         // The double lands among the single denormals.
         f_ok   = (d_man[29:0] == '0) && ((sub_sig & ~(23'h7fffff << sub_sh)) == '0);
         f_bits = {d_sign, 8'd0, sub_sig >> sub_sh};
      end
   end

   // Single to half, exact only.
   assign f_exp     = f_bits[30:23];
   assign f_man     = f_bits[22:0];
   assign h_exp_adj = f_exp - 8'd112;
   assign h_sh      = 5'(8'd126 - f_exp);
   assign h_sig     = {1'b1, f_man};
   assign h_shifted = h_sig >> h_sh;

   always_comb begin
      h_ok   = 1'b0;
      h_bits = {f_bits[31], 15'd0};
      if (f_bits[12:0] != '0) begin
         h_ok = 1'b0;
      end else if (f_exp == '0 && f_man == '0) begin
         h_ok = 1'b1;
      end else if (f_exp >= 8'd113 && f_exp <= 8'd142) begin
         h_ok   = 1'b1;
         h_bits = {f_bits[31], h_exp_adj[4:0], f_man[22:13]};
      end else if (f_exp >= 8'd103 && f_exp <= 8'd112) begin
         h_ok   = ((f_man & ~(23'h7fffff << h_sh)) == '0);
         h_bits = {f_bits[31], h_shifted[14:0]};
      end else if (f_exp == 8'hff && f_man == '0) begin
         h_ok   = 1'b1;
         h_bits = {f_bits[31], 15'h7c00};
      end
   end

   always_comb begin
      dbl_elem = '0;
      if (d_nan) begin
         dbl_elem.head    = HEAD_HALF;
         dbl_elem.arg     = {16'h7e00, 48'd0};
         dbl_elem.arg_len = 4'd2;
      end else if (!f_ok) begin
         dbl_elem.head    = HEAD_DOUBLE;
         dbl_elem.arg     = req_data.value;
         dbl_elem.arg_len = 4'd8;
      end else if (h_ok) begin
         dbl_elem.head    = HEAD_HALF;
         dbl_elem.arg     = {h_bits, 48'd0};
         dbl_elem.arg_len = 4'd2;
      end else begin
         dbl_elem.head    = HEAD_SINGLE;
         dbl_elem.arg     = {f_bits, 32'd0};
         dbl_elem.arg_len = 4'd4;
      end
   end

   always_comb begin
      elem   = '0;
      cmd_ok = 1'b1;
      unique case (req_data.command)
         CMD_NULL:   elem.head = SIMPLE_NULL;
         CMD_UNDEF:  elem.head = SIMPLE_UNDEF;
         CMD_BOOL:   elem.head = req_data.value[0] ? SIMPLE_TRUE : SIMPLE_FALSE;
         CMD_UINT:   elem = make_head(MT_UINT, req_data.value);
         // A zero magnitude wraps to all ones, which is the argument of -2^64.
         CMD_NEGINT: elem = make_head(MT_NEG, req_data.value - 64'd1);
         CMD_DOUBLE: elem = dbl_elem;
         CMD_TEXT:   elem = make_head(MT_TEXT, req_data.value);
         CMD_BYTES:  elem = make_head(MT_BYTES, req_data.value);
         CMD_ARRAY:  elem = make_head(MT_ARRAY, req_data.value);
         CMD_MAP:    elem = make_head(MT_MAP, req_data.value);
         CMD_RAW:    elem.head = req_data.value[7:0];
         default:    cmd_ok = 1'b0;
      endcase
   end

   assign full   = q_full;
   assign q_push = push && !q_full && cmd_ok;
   assign q_data = elem;

endmodule
`default_nettype wire

>>> hw/rtl/cbor_enc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module cbor_enc_queue import cbor_enc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     wr_en,
   input  wire elem_type wr_data,
   output logic          full,
   input  wire logic     rd_en,
   output elem_type      rd_data,
   output logic          empty
);

   elem_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full    = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(wr_en);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(rd_en);
      count_in  = count_ff + (QUEUE_AW + 1)'(wr_en) - (QUEUE_AW + 1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/cbor_enc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cbor_enc_back import cbor_enc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_empty,
   input  wire elem_type q_data,
   output logic          q_pop,
   output logic          empty,
   input  wire logic     pop,
   output rsp_type       rsp_data
);

   logic [3:0]  rem_ff, rem_in;
   logic [63:0] shift_ff, shift_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        advance;

   // The output register takes a new byte when it is free or being drained.
   assign advance = !out_valid_ff || pop;
   assign q_pop   = advance && (rem_ff == '0) && !q_empty;

   always_comb begin
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         if (rem_ff != '0) begin
            out_in.out_byte  = shift_ff[63:56];
            out_in.last_byte = (rem_ff == 4'd1);
            shift_in         = {shift_ff[55:0], 8'd0};
            rem_in           = rem_ff - 4'd1;
            out_valid_in     = 1'b1;
         end else if (!q_empty) begin
            out_in.out_byte  = q_data.head;
            out_in.last_byte = (q_data.arg_len == '0);
            shift_in         = q_data.arg;
            rem_in           = q_data.arg_len;
            out_valid_in     = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      out_ff   <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

`ifndef SYNTH
   // Bytes still owed for an element imply a byte of it is on display.
   a_rem_has_output: assert property (@(posedge clock) disable iff (reset)
      rem_ff != '0 |-> out_valid_ff) else $error("argument bytes pending with no output");

   // A shown byte that is not last must have more bytes behind it.
   a_not_last_has_more: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.last_byte) |-> rem_ff != '0)
      else $error("element ended without a last byte");

   // No new element starts while the current one still has bytes to send.
   a_pop_only_between: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (rem_ff == '0 && !q_empty)) else $error("queue read out of turn");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 4'd8) else $error("argument byte count out of range");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/cbor_data_item_head_encoder.sv
`timescale 1ns / 1ps
// A request's head byte is written into the queue and then into the output register before
// it reaches the result ports. Throughput: one result byte per cycle while pop is high and
// bytes are waiting; a request yields 1 + n bytes, n being 0, 1, 2, 4 or 8 argument bytes.
// A four-entry queue takes one request per cycle until it fills. Reset is synchronous and
// active high; it empties the queue and the output register; no other state needs clearing.
`default_nettype none
module cbor_data_item_head_encoder import cbor_enc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   // The front end classifies each request in the cycle it is pushed: it
   // picks the head byte, the number of argument bytes and the argument,
   // already aligned so that the first byte to send sits in the top byte.
   // Doubles are narrowed to single or half precision here when exact.
   // Commands without meaning are accepted and dropped, producing no bytes.
   logic     q_push;
   elem_type q_wr_data;
   logic     q_full;
   logic     q_pop;
   elem_type q_rd_data;
   logic     q_empty;

   cbor_enc_front u_front (
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   // The queue decouples classification from serialization, so a long
   // head such as an eight-byte integer does not stall the request side
   // until the queue fills.
   cbor_enc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   // The back end shifts out the head and argument bytes one per cycle while pop
   // is high, through an output register, and marks the final byte of each element.
   // It fetches the next element in the same cycle the previous element's
   // last byte is handed over, so back-to-back elements leave no bubbles.
   cbor_enc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import cbor_enc_pkg::*;

   // A request waiting to be offered. With drain_first set, the sender holds
   // it back until every result byte expected so far has been popped.
   typedef struct {
      req_type req;
      bit      drain_first;
   } stim_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   stim_item_type stim_queue[$];
   rsp_type       expected_bytes[$];

   stim_item_type next_item;
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned recv_gap = 0;
   int unsigned recv_calm = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned requests_accepted = 0;
   int unsigned results_seen = 0;
   int unsigned full_stall_cycles = 0;
   int unsigned failures = 0;
   int unsigned cmd_counts[16];

   cbor_data_item_head_encoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Encoding predictor
   // ------------------------------------------------------------------

   // Appends a head byte followed by arg_bytes bytes of arg, most significant
   // first. The final byte of the element carries the last flag.
   function automatic void queue_bytes(logic [7:0] head, logic [63:0] arg,
                                       int unsigned arg_bytes);
      rsp_type     b;
      int unsigned k;
      b.out_byte  = head;
      b.last_byte = (arg_bytes == 0);
      expected_bytes.insert(expected_bytes.size(), b);
      for (k = 0; k < arg_bytes; k++) begin
         b.out_byte  = arg[8 * (arg_bytes - 1 - k) +: 8];
         b.last_byte = (k == arg_bytes - 1);
         expected_bytes.insert(expected_bytes.size(), b);
      end
   endfunction

   // Shortest head form: the argument goes into the head byte itself when it
   // is below 24, otherwise into 1, 2, 4 or 8 following bytes.
   function automatic void queue_head(logic [7:0] major, logic [63:0] arg);
      if (arg < 64'd24)
         queue_bytes(major + arg[7:0], '0, 0);
      else if (arg < 64'd256)
         queue_bytes(major | {3'b000, AI_ONE}, arg, 1);
      else if (arg < 64'd65536)
         queue_bytes(major | {3'b000, AI_TWO}, arg, 2);
      else if (arg < 64'h1_0000_0000)
         queue_bytes(major | {3'b000, AI_FOUR}, arg, 4);
      else
         queue_bytes(major | {3'b000, AI_EIGHT}, arg, 8);
   endfunction

   // Narrows single precision bits to half precision. Returns 0 when some
   // bit of the value would be lost.
   function automatic bit half_from_single(logic [31:0] f, output logic [15:0] h);
      logic [31:0] acc;
      logic [31:0] ex;
      logic [31:0] man;
      int unsigned sh;
      acc = {16'd0, f[31], 15'd0};
      ex  = {24'd0, f[30:23]};
      man = {9'd0, f[22:0]};
      h   = '0;
      if (f[12:0] != 0)
         return 1'b0;
      if (ex == 0 && man == 0) begin
         // Signed zero: only the sign survives.
      end else if (ex >= 113 && ex <= 142) begin
         acc += ((ex - 32'd112) << 10) + (man >> 13);
      end else if (ex >= 103 && ex < 113) begin
         // Lands in the half denormal range; the shifted-out bits must be zero.
         sh = 126 - ex;
         if ((man & ((32'd1 << sh) - 32'd1)) != 0)
            return 1'b0;
         acc += (man + 32'h0080_0000) >> sh;
      end else if (ex == 255 && man == 0) begin
         acc += 32'h7c00;
      end else begin
         return 1'b0;
      end
      h = acc[15:0];
      return 1'b1;
   endfunction

   // Doubles go out in the narrowest form that keeps the value exactly.
   function automatic void queue_double(logic [63:0] d);
      logic [10:0] e;
      logic [51:0] m;
      logic [63:0] sig;
      logic [31:0] f;
      logic [15:0] h;
      bit          fits_single;
      int          ue;
      int unsigned sh;
      e           = d[62:52];
      m           = d[51:0];
      sig         = {11'd0, 1'b1, m};
      f           = {d[63], 31'd0};
      fits_single = 1'b0;
      if (e == 11'h7ff && m != 0) begin
         // Every NaN collapses to the canonical half NaN.
         queue_bytes(HEAD_HALF, 64'h7e00, 2);
         return;
      end
      if (e == 11'h000 && m == 0) begin
         fits_single = 1'b1;
      end else if (e == 11'h7ff) begin
         fits_single = 1'b1;
         f[30:23]    = 8'hff;
      end else if (e != 11'h000) begin
         ue = e;
         ue = ue - 1023;
         if (ue >= -126 && ue <= 127) begin
            if (m[28:0] == 0) begin
               fits_single = 1'b1;
               f[30:23]    = 8'(ue + 127);
               f[22:0]     = m[51:29];
            end
         end else if (ue >= -149 && ue < -126) begin
            // Becomes a single precision denormal.
            sh = -97 - ue;
            if ((sig & ((64'd1 << sh) - 64'd1)) == 0) begin
               fits_single = 1'b1;
               f[22:0]     = 23'(sig >> sh);
            end
         end
      end
      // Double denormals never fit a float and fall through to here.
      if (!fits_single)
         queue_bytes(HEAD_DOUBLE, d, 8);
      else if (half_from_single(f, h))
         queue_bytes(HEAD_HALF, {48'd0, h}, 2);
      else
         queue_bytes(HEAD_SINGLE, {32'd0, f}, 4);
   endfunction

   function automatic void encode_request(req_type r);
      case (r.command)
         CMD_NULL:   queue_bytes(SIMPLE_NULL, '0, 0);
         CMD_UNDEF:  queue_bytes(SIMPLE_UNDEF, '0, 0);
         CMD_BOOL:   queue_bytes(r.value[0] ? SIMPLE_TRUE : SIMPLE_FALSE, '0, 0);
         CMD_UINT:   queue_head(MT_UINT, r.value);
         // A zero magnitude stands for 2^64; the wrap of value - 1 gives the
         // all-ones argument that it needs.
         CMD_NEGINT: queue_head(MT_NEG, r.value - 64'd1);
         CMD_DOUBLE: queue_double(r.value);
         CMD_TEXT:   queue_head(MT_TEXT, r.value);
         CMD_BYTES:  queue_head(MT_BYTES, r.value);
         CMD_ARRAY:  queue_head(MT_ARRAY, r.value);
         CMD_MAP:    queue_head(MT_MAP, r.value);
         CMD_RAW:    queue_bytes(r.value[7:0], '0, 0);
         default: begin
            // Unused command codes encode to nothing.
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic void add_request(logic [3:0] command, logic [63:0] value,
                                       bit drain_first = 1'b0);
      stim_item_type it;
      it.req.command = command;
      it.req.value   = value;
      it.drain_first = drain_first;
      stim_queue.insert(stim_queue.size(), it);
   endfunction

   // Mostly short gaps, a few long ones, and now and then a calm stretch
   // with no gaps at all.
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
         calm = $urandom_range(40, 10);
         return 0;
      end
      if (roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(3, 1);
      if (roll < 98)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Lengths and integers spread over every head size, with the size
   // boundaries picked often.
   function automatic logic [63:0] rand_argument();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(7))
         0: return 64'($urandom_range(23));
         1: return 64'($urandom_range(255, 24));
         2: return 64'($urandom_range(65535, 256));
         3: return 64'($urandom_range(32'hffff_ffff, 65536));
         4: return wide;
         5: begin
            case ($urandom_range(9))
               0: return 64'd0;
               1: return 64'd23;
               2: return 64'd24;
               3: return 64'd255;
               4: return 64'd256;
               5: return 64'd65535;
               6: return 64'd65536;
               7: return 64'hffff_ffff;
               8: return 64'h1_0000_0000;
               default: return '1;
            endcase
         end
         6: return wide >> $urandom_range(63);
         default: return 64'($urandom_range(40));
      endcase
   endfunction

   // Doubles built so that many are exactly a float or a half, including the
   // denormal ranges of both, alongside plain doubles and the special values.
   function automatic logic [63:0] rand_double();
      logic [63:0] bits;
      int unsigned k;
      bits = {$urandom, $urandom};
      case ($urandom_range(9))
         0: return bits;
         1: begin
            bits[62:52] = $urandom_range(1) ? 11'h7ff : 11'h000;
            if ($urandom_range(1))
               bits[51:0] = '0;
            return bits;
         end
         default: begin
            bits[62:52] = 11'($urandom_range(1023 + 135, 1023 - 160));
            case ($urandom_range(4))
               0: k = 29;
               1: k = 42;
               2: k = $urandom_range(52, 45);
               3: k = 52;
               default: k = $urandom_range(52);
            endcase
            bits[51:0] = bits[51:0] & ~((52'd1 << k) - 52'd1);
            return bits;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------

   // A request moves at an edge where push is high and full is low. The
   // expected encoding is queued at that same edge, so it is always in place
   // before the first byte of the element can appear. A refused request is
   // held unchanged until it goes through.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            encode_request(req_data);
            requests_accepted++;
            cmd_counts[req_data.command]++;
            send_gap = pick_gap(send_calm);
            // Keep offering while the receiver holds off, so the queue fills.
            if (rsp_hold_left > 0)
               send_gap = 0;
         end
         if (push && full) begin
            full_stall_cycles++;
         end else if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
         end else if (stim_queue.size() > 0 &&
                      (!stim_queue[0].drain_first || expected_bytes.size() == 0)) begin
            next_item = stim_queue.pop_front();
            req_data <= next_item.req;
            push     <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------

   // Each popped byte is checked against the oldest expectation. Pop is
   // raised and lowered at random, and from time to time it is held low
   // so that the block backs up to its input.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen++;
            if (expected_bytes.size() == 0) begin
               if (failures < 10)
                  $display("ERROR: unexpected result byte %h last %b",
                           rsp_data.out_byte, rsp_data.last_byte);
               failures++;
            end else begin
               if (rsp_data.out_byte !== expected_bytes[0].out_byte ||
                   rsp_data.last_byte !== expected_bytes[0].last_byte) begin
                  if (failures < 10)
                     $display("ERROR: result %0d: byte %h last %b, expected byte %h last %b",
                              results_seen, rsp_data.out_byte, rsp_data.last_byte,
                              expected_bytes[0].out_byte, expected_bytes[0].last_byte);
                  failures++;
               end
               void'(expected_bytes.pop_front());
            end
            if (results_seen % 400 == 150)
               rsp_hold_left = 300;
            else
               recv_gap = pick_gap(recv_calm);
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            pop <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------

   initial begin
      int unsigned counted;
      int unsigned n;
      int unsigned i;
      int unsigned roll;
      int unsigned unused_codes;
      bit          pause_done;
      logic [3:0]  command;
      logic [63:0] value;

      foreach (cmd_counts[c])
         cmd_counts[c] = 0;

      // Directed requests: the simple values, bool with its upper bits set,
      // head size boundaries, the zero-magnitude negative integer, signed
      // zero, infinity, NaN, doubles that fit a half, a single or neither, a
      // half denormal, a double denormal, every string and container head, raw
      // bytes with junk in the upper bits and two of the unused command codes.
      add_request(CMD_NULL,   64'd0);
      add_request(CMD_UNDEF,  64'd0);
      add_request(CMD_BOOL,   '1);
      add_request(CMD_BOOL,   64'hffff_ffff_ffff_fffe);
      add_request(CMD_UINT,   64'd23);
      add_request(CMD_UINT,   64'd24);
      add_request(CMD_UINT,   64'd65536);
      add_request(CMD_UINT,   '1);
      add_request(CMD_NEGINT, 64'd0);
      add_request(CMD_NEGINT, 64'd24);
      add_request(CMD_NEGINT, 64'd257);
      add_request(CMD_DOUBLE, 64'h8000_0000_0000_0000);
      add_request(CMD_DOUBLE, 64'h7ff0_0000_0000_0000);
      add_request(CMD_DOUBLE, 64'hfff0_0000_0000_0000);
      add_request(CMD_DOUBLE, 64'h7ff0_0000_0000_0001);
      add_request(CMD_DOUBLE, 64'h3ff0_0000_0000_0000);
      add_request(CMD_DOUBLE, 64'h3e70_0000_0000_0000);
      add_request(CMD_DOUBLE, 64'h3ff0_0000_2000_0000);
      add_request(CMD_DOUBLE, 64'h3fb9_9999_9999_999a);
      add_request(CMD_DOUBLE, 64'h0000_0000_0000_0001);
      add_request(CMD_TEXT,   64'd0);
      add_request(CMD_BYTES,  64'd255);
      add_request(CMD_ARRAY,  64'hffff_ffff);
      add_request(CMD_MAP,    64'h1_0000_0000);
      add_request(CMD_RAW,    64'hffff_ffff_ffff_ffa5);
      add_request(4'd11,      64'd0);
      add_request(4'd15,      '1);

      // Random requests. Strings come as a head followed by their payload
      // bytes and containers as a head followed by integer members of any size;
      // the rest are single elements of any kind. The sender drains the block
      // before the random part starts and once more about half way through.
      counted    = 0;
      pause_done = 1'b0;
      add_request(CMD_UINT, rand_argument(), 1'b1);
      while (counted < 454) begin
         roll = $urandom_range(99);
         if (!pause_done && counted >= 250) begin
            add_request(CMD_DOUBLE, rand_double(), 1'b1);
            pause_done = 1'b1;
            counted++;
         end else if (roll < 3) begin
            add_request(4'($urandom_range(15, 11)), {$urandom, $urandom});
         end else if (roll < 20) begin
            n = $urandom_range(6);
            add_request($urandom_range(1) ? CMD_TEXT : CMD_BYTES, 64'(n));
            for (i = 0; i < n; i++)
               add_request(CMD_RAW, {$urandom, $urandom});
            counted += n + 1;
         end else if (roll < 30) begin
            n = $urandom_range(4);
            command = $urandom_range(1) ? CMD_ARRAY : CMD_MAP;
            add_request(command, 64'(n));
            if (command == CMD_MAP)
               n = 2 * n;
            for (i = 0; i < n; i++)
               add_request(CMD_UINT, rand_argument());
            counted += n + 1;
         end else begin
            command = (roll < 55) ? CMD_DOUBLE : 4'($urandom_range(10));
            case (command)
               CMD_DOUBLE: value = rand_double();
               CMD_NEGINT: value = rand_argument() + 64'd1;
               CMD_UINT, CMD_TEXT, CMD_BYTES, CMD_ARRAY, CMD_MAP:
                  value = rand_argument();
               default: value = {$urandom, $urandom};
            endcase
            add_request(command, value);
            counted++;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Sampled on the falling edge, after the driver's updates have settled.
      while (stim_queue.size() != 0 || push || expected_bytes.size() != 0)
         @(negedge clock);
      // Let any stray trailing bytes surface before the verdict.
      repeat (20) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $display("ERROR: %0d expected result bytes never arrived", expected_bytes.size());
         failures++;
      end

      unused_codes = 0;
      for (i = 11; i < 16; i++)
         unused_codes += cmd_counts[i];

      $display("Checked %0d result bytes from %0d requests; input held off by a full %s",
               results_seen, requests_accepted, "queue on some cycles");
      $display("Doubles %0d, integers %0d, heads %0d, raw bytes %0d,",
               cmd_counts[CMD_DOUBLE], cmd_counts[CMD_UINT] + cmd_counts[CMD_NEGINT],
               cmd_counts[CMD_TEXT] + cmd_counts[CMD_BYTES] + cmd_counts[CMD_ARRAY] +
               cmd_counts[CMD_MAP], cmd_counts[CMD_RAW]);
      $display("unused codes %0d, full stalls %0d", unused_codes, full_stall_cycles);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #15_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
